[rtl/core/rrtw_pkg.sv]
// Shared types, constants and the sine table for the rotated-rectangle
// tile-wall collision block. No dependencies.
package rrtw_pkg;

  // Write indexes are 5-bit fields, so at most 32 rows and columns are ever stored.
  localparam int MAX_IDX = 32;

  localparam int CNW   = 19;  // 2*pos + size
  localparam int LW    = 26;  // corner offset, Q9.16
  localparam int TW    = 41;  // offset times sine or cosine
  localparam int BW    = 35;  // center dot axis, before the 2^21 scale
  localparam int KW    = 31;  // s*s + c*c
  localparam int KPW   = 56;  // offset times (s*s + c*c)
  localparam int XW    = 43;  // corner coordinate, Q12.30
  localparam int PW    = 58;  // projection onto a rectangle axis
  localparam int HW    = 28;  // projection bound in whole cells
  localparam int FW    = 14;  // box bound in cells
  localparam int VW    = 22;  // cell projection onto a rectangle axis
  localparam int FRAC  = 30;
  localparam int CSH   = 21;
  localparam int CQ_DEPTH = 2;

  localparam logic signed [PW-1:0] ONE_M1 = PW'((64'sd1 <<< FRAC) - 64'sd1);

  localparam logic signed [15:0] SIN_TAB [91] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // Sine of a reduced angle (0..359) in Q1.14.
  function automatic logic signed [15:0] sin_q14(input logic [8:0] d);
    logic [8:0] k;
    logic       neg;
    priority if (d <= 9'd90) begin
      k = d;
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      k = 9'd180 - d;
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      k = d - 9'd180;
      neg = 1'b1;
    end else begin
      k = 9'd360 - d;
      neg = 1'b1;
    end
    return neg ? 16'sd0 - SIN_TAB[k[6:0]] : SIN_TAB[k[6:0]];
  endfunction

  typedef struct packed {
    logic                  query;
    logic                  wr_ok;
    logic [4:0]            row;
    logic [4:0]            col;
    logic                  wall;
    logic signed [CNW-1:0] ctrx;
    logic signed [CNW-1:0] ctry;
    logic [15:0]           w;
    logic [15:0]           h;
    logic [8:0]            anc_x;
    logic [8:0]            anc_y;
    logic signed [15:0]    s;
    logic signed [15:0]    c;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WRD, B_WWR, B_GEO, B_FA, B_FB, B_FC, B_FD, B_ROWRD, B_COLS, B_DONE
  } bstate_t;

  // Multiply steps of the geometry sequencer, in issue order.
  typedef enum logic [4:0] {
    MS_LXL, MS_LXR, MS_LYT, MS_LYB, MS_SS, MS_CC,
    MS_XCL, MS_XCR, MS_YST, MS_YSB, MS_XSL, MS_XSR, MS_YCT, MS_YCB,
    MS_B0A, MS_B0B, MS_B1A, MS_B1B,
    MS_KYT, MS_KYB, MS_KXL, MS_KXR, MS_END
  } mstep_t;

endpackage

[rtl/core/rrtw_front.sv]
// Front part: accepts requests, classifies them and looks up sine and cosine.
// Depends on rrtw_pkg.
module rrtw_front import rrtw_pkg::*; #(
  parameter int MAP_ROWS = 32,
  parameter int MAP_COLS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [4:0]         cell_row,
  input  logic [4:0]         cell_col,
  input  logic               wall_bit,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        rect_width,
  input  logic [15:0]        rect_height,
  input  logic [8:0]         angle_deg,
  input  logic [8:0]         anchor_x,
  input  logic [8:0]         anchor_y,
  output logic               q_push,
  output cmd_t               q_item,
  input  logic               q_full
);

  logic       f_valid;
  cmd_t       f_cmd;
  cmd_t       cls;
  logic       accept;
  logic [8:0] a_red;
  logic [8:0] a90;

  assign accept = push && !full;
  assign full   = f_valid && q_full;
  assign q_push = f_valid;
  assign q_item = f_cmd;

  always_comb begin
    a_red = (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
    a90   = a_red + 9'd90;
    if (a90 >= 9'd360) begin
      a90 = a90 - 9'd360;
    end
    cls.query = opcode;
    cls.wr_ok = (32'(cell_row) < MAP_ROWS) && (32'(cell_col) < MAP_COLS);
    cls.row   = cell_row;
    cls.col   = cell_col;
    cls.wall  = wall_bit;
    cls.ctrx  = {{2{pos_x[15]}}, pos_x, 1'b0} + {3'b000, rect_width};
    cls.ctry  = {{2{pos_y[15]}}, pos_y, 1'b0} + {3'b000, rect_height};
    cls.w     = rect_width;
    cls.h     = rect_height;
    cls.anc_x = anchor_x;
    cls.anc_y = anchor_y;
    cls.s     = sin_q14(a_red);
    cls.c     = sin_q14(a90);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept || (f_valid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= cls;
    end
  end

endmodule

[rtl/core/rrtw_cmdq.sv]
// Short request queue between the front and the back part.
// Depends on rrtw_pkg.
module rrtw_cmdq import rrtw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t item_in,
  output logic full,
  input  logic pop,
  output cmd_t item_out,
  output logic empty
);

  localparam int AW = $clog2(CQ_DEPTH);

  cmd_t        ents [CQ_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign full     = (cnt == (AW+1)'(CQ_DEPTH));
  assign empty    = (cnt == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = ents[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(CQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(CQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ents[wp] <= item_in;
    end
  end

endmodule

[rtl/core/rrtw_back.sv]
// Back part: wall map, geometry sequencer on one shared multiplier, cell walk
// and the result register. Depends on rrtw_pkg.
module rrtw_back import rrtw_pkg::*; #(
  parameter int MAP_ROWS = 32,
  parameter int MAP_COLS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_item,
  output logic q_pop,
  input  logic pop,
  output logic empty,
  output logic collides
);

  localparam int RROWS = (MAP_ROWS < MAX_IDX) ? MAP_ROWS : MAX_IDX;
  localparam int RCOLS = (MAP_COLS < MAX_IDX) ? MAP_COLS : MAX_IDX;
  localparam int RIW   = (RROWS > 1) ? $clog2(RROWS) : 1;
  localparam int CIW   = (RCOLS > 1) ? $clog2(RCOLS) : 1;
  localparam logic signed [FW-1:0] CMAX = FW'(RCOLS - 1);
  localparam logic signed [FW-1:0] RMAX = FW'(RROWS - 1);

  bstate_t state, state_next;
  cmd_t    cmd;
  mstep_t  st, pst;

  logic [RCOLS-1:0] mem [RROWS];
  logic [RROWS-1:0] row_vld;
  logic [RCOLS-1:0] rd_data;
  logic             rd_vld;
  logic [RCOLS-1:0] wd;
  logic [RIW-1:0]   ra;
  logic             mem_we;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic signed [LW-1:0]  lxl, lxr, lyt, lyb;
  logic signed [KW-1:0]  kk;
  logic signed [TW-1:0]  xcl, xcr, yst, ysb, xsl, xsr, yct, ycb;
  logic signed [BW-1:0]  b0, b1;
  logic signed [KPW-1:0] kyt, kyb, kxl, kxr;

  logic signed [TW-1:0]  mn_xc, mx_xc, mn_ys, mx_ys, mn_xs, mx_xs, mn_yc, mx_yc;
  logic signed [KPW-1:0] mn_ky, mx_ky, mn_kx, mx_kx;
  logic signed [XW-1:0]  minx, maxx, miny, maxy;
  logic signed [PW-1:0]  hia0, loa0, hia1, loa1;
  logic signed [HW-1:0]  ha0, la0, ha1, la1;
  logic signed [FW-1:0]  c0, c1, r0, r1;

  logic signed [9:0]  nax, pax, nay, pay;
  logic signed [16:0] w17, h17;
  logic signed [15:0] ns, nc;
  logic signed [XW-1:0] ctrx_f, ctry_f;
  logic signed [PW-1:0] b0_f, b1_f;

  logic signed [16:0] lo_off0, hi_off0, lo_off1, hi_off1;
  logic signed [VW-1:0] rb0, rb1, v0, v1;
  logic [RIW-1:0] r_idx;
  logic [CIW-1:0] q_idx;
  logic signed [HW-1:0] lob0, hib0, lob1, hib1;
  logic sep0, sep1, hit, last_col, last_row, box_empty;
  logic res;
  logic out_vld;

  assign nax = 10'sd0 - signed'({1'b0, cmd.anc_x});
  assign pax = 10'sd256 - signed'({1'b0, cmd.anc_x});
  assign nay = 10'sd0 - signed'({1'b0, cmd.anc_y});
  assign pay = 10'sd256 - signed'({1'b0, cmd.anc_y});
  assign w17 = signed'({1'b0, cmd.w});
  assign h17 = signed'({1'b0, cmd.h});
  assign ns  = 16'sd0 - cmd.s;
  assign nc  = 16'sd0 - cmd.c;
  assign ctrx_f = XW'(cmd.ctrx) <<< CSH;
  assign ctry_f = XW'(cmd.ctry) <<< CSH;
  assign b0_f   = PW'(b0) <<< CSH;
  assign b1_f   = PW'(b1) <<< CSH;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      MS_LXL: begin mul_a = 32'(nax); mul_b = 32'(w17); end
      MS_LXR: begin mul_a = 32'(pax); mul_b = 32'(w17); end
      MS_LYT: begin mul_a = 32'(nay); mul_b = 32'(h17); end
      MS_LYB: begin mul_a = 32'(pay); mul_b = 32'(h17); end
      MS_SS:  begin mul_a = 32'(cmd.s); mul_b = 32'(cmd.s); end
      MS_CC:  begin mul_a = 32'(cmd.c); mul_b = 32'(cmd.c); end
      MS_XCL: begin mul_a = 32'(lxl); mul_b = 32'(cmd.c); end
      MS_XCR: begin mul_a = 32'(lxr); mul_b = 32'(cmd.c); end
      MS_YST: begin mul_a = 32'(lyt); mul_b = 32'(cmd.s); end
      MS_YSB: begin mul_a = 32'(lyb); mul_b = 32'(cmd.s); end
      MS_XSL: begin mul_a = 32'(lxl); mul_b = 32'(cmd.s); end
      MS_XSR: begin mul_a = 32'(lxr); mul_b = 32'(cmd.s); end
      MS_YCT: begin mul_a = 32'(lyt); mul_b = 32'(cmd.c); end
      MS_YCB: begin mul_a = 32'(lyb); mul_b = 32'(cmd.c); end
      MS_B0A: begin mul_a = 32'(cmd.ctry); mul_b = 32'(cmd.c); end
      MS_B0B: begin mul_a = 32'(cmd.ctrx); mul_b = 32'(cmd.s); end
      MS_B1A: begin mul_a = 32'(cmd.ctrx); mul_b = 32'(cmd.c); end
      MS_B1B: begin mul_a = 32'(cmd.ctry); mul_b = 32'(cmd.s); end
      MS_KYT: begin mul_a = 32'(lyt); mul_b = 32'(kk); end
      MS_KYB: begin mul_a = 32'(lyb); mul_b = 32'(kk); end
      MS_KXL: begin mul_a = 32'(lxl); mul_b = 32'(kk); end
      MS_KXR: begin mul_a = 32'(lxr); mul_b = 32'(kk); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Cell test on the two rectangle axes; the grid axes never separate inside the box.
  always_comb begin
    lob0 = HW'(v0) + HW'(lo_off0);
    hib0 = HW'(v0) + HW'(hi_off0);
    lob1 = HW'(v1) + HW'(lo_off1);
    hib1 = HW'(v1) + HW'(hi_off1);
    sep0 = (|cmd.w) && ((ha0 < lob0) || (hib0 < la0));
    sep1 = (|cmd.h) && ((ha1 < lob1) || (hib1 < la1));
    hit  = rd_vld && rd_data[q_idx] && !sep0 && !sep1;
    last_col  = (q_idx == c1[CIW-1:0]);
    last_row  = (r_idx == r1[RIW-1:0]);
    box_empty = (c0 > c1) || (r0 > r1);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = q_item.query ? B_GEO : B_WRD;
        end
      end
      B_WRD:   state_next = B_WWR;
      B_WWR:   state_next = B_DONE;
      B_GEO:   if (st == MS_END) state_next = B_FA;
      B_FA:    state_next = B_FB;
      B_FB:    state_next = B_FC;
      B_FC:    state_next = B_FD;
      B_FD:    state_next = box_empty ? B_DONE : B_ROWRD;
      B_ROWRD: state_next = B_COLS;
      B_COLS: begin
        priority if (hit) begin
          state_next = B_DONE;
        end else if (last_col && last_row) begin
          state_next = B_DONE;
        end else if (last_col) begin
          state_next = B_ROWRD;
        end
      end
      B_DONE:  if (!out_vld || pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Wall map: row read is registered; rows never written read as clear.
  assign ra     = (state == B_WRD) ? cmd.row[RIW-1:0] : r_idx;
  assign mem_we = (state == B_WWR) && cmd.wr_ok;

  always_comb begin
    wd = rd_vld ? rd_data : '0;
    wd[cmd.col[CIW-1:0]] = cmd.wall;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.row[RIW-1:0]] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= row_vld[ra];
      if (mem_we) begin
        row_vld[cmd.row[RIW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == B_DONE && (!out_vld || pop)) begin
      out_vld <= 1'b1;
    end else if (pop) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && (!out_vld || pop)) begin
      collides <= res;
    end
  end

  assign empty = !out_vld;

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cmd <= q_item;
        end
        st  <= MS_LXL;
        pst <= MS_LXL;
        res <= 1'b0;
      end
      B_GEO: begin
        prod <= mul_a * mul_b;
        pst  <= st;
        if (st != MS_END) begin
          st <= mstep_t'(st + 5'd1);
        end
        if (st != MS_LXL) begin
          unique case (pst)
            MS_LXL: lxl <= prod[LW-1:0];
            MS_LXR: lxr <= prod[LW-1:0];
            MS_LYT: lyt <= prod[LW-1:0];
            MS_LYB: lyb <= prod[LW-1:0];
            MS_SS:  kk  <= prod[KW-1:0];
            MS_CC:  kk  <= kk + prod[KW-1:0];
            MS_XCL: xcl <= prod[TW-1:0];
            MS_XCR: xcr <= prod[TW-1:0];
            MS_YST: yst <= prod[TW-1:0];
            MS_YSB: ysb <= prod[TW-1:0];
            MS_XSL: xsl <= prod[TW-1:0];
            MS_XSR: xsr <= prod[TW-1:0];
            MS_YCT: yct <= prod[TW-1:0];
            MS_YCB: ycb <= prod[TW-1:0];
            MS_B0A: b0  <= prod[BW-1:0];
            MS_B0B: b0  <= b0 - prod[BW-1:0];
            MS_B1A: b1  <= '0 - prod[BW-1:0];
            MS_B1B: b1  <= b1 - prod[BW-1:0];
            MS_KYT: kyt <= prod[KPW-1:0];
            MS_KYB: kyb <= prod[KPW-1:0];
            MS_KXL: kxl <= prod[KPW-1:0];
            MS_KXR: kxr <= prod[KPW-1:0];
            default: ;
          endcase
        end
      end
      B_FA: begin
        // The four corners take every pairing of the two x and two y offsets.
        mn_xc <= (xcl < xcr) ? xcl : xcr;
        mx_xc <= (xcl < xcr) ? xcr : xcl;
        mn_ys <= (yst < ysb) ? yst : ysb;
        mx_ys <= (yst < ysb) ? ysb : yst;
        mn_xs <= (xsl < xsr) ? xsl : xsr;
        mx_xs <= (xsl < xsr) ? xsr : xsl;
        mn_yc <= (yct < ycb) ? yct : ycb;
        mx_yc <= (yct < ycb) ? ycb : yct;
        mn_ky <= (kyt < kyb) ? kyt : kyb;
        mx_ky <= (kyt < kyb) ? kyb : kyt;
        mn_kx <= (kxl < kxr) ? kxl : kxr;
        mx_kx <= (kxl < kxr) ? kxr : kxl;
      end
      B_FB: begin
        minx <= ctrx_f + XW'(mn_xc) - XW'(mx_ys);
        maxx <= ctrx_f + XW'(mx_xc) - XW'(mn_ys);
        miny <= ctry_f + XW'(mn_xs) + XW'(mn_yc);
        maxy <= ctry_f + XW'(mx_xs) + XW'(mx_yc);
        hia0 <= b0_f + PW'(mx_ky);
        loa0 <= b0_f + PW'(mn_ky) + ONE_M1;
        hia1 <= b1_f - PW'(mn_kx);
        loa1 <= b1_f - PW'(mx_kx) + ONE_M1;
      end
      B_FC: begin
        c0  <= (FW'(minx >>> FRAC) < 14'sd0) ? 14'sd0 : FW'(minx >>> FRAC);
        c1  <= (FW'(maxx >>> FRAC) > CMAX) ? CMAX : FW'(maxx >>> FRAC);
        r0  <= (FW'(miny >>> FRAC) < 14'sd0) ? 14'sd0 : FW'(miny >>> FRAC);
        r1  <= (FW'(maxy >>> FRAC) > RMAX) ? RMAX : FW'(maxy >>> FRAC);
        ha0 <= HW'(hia0 >>> FRAC);
        la0 <= HW'(loa0 >>> FRAC);
        ha1 <= HW'(hia1 >>> FRAC);
        la1 <= HW'(loa1 >>> FRAC);
      end
      B_FD: begin
        rb0 <= VW'(c0) * VW'(ns) + VW'(r0) * VW'(cmd.c);
        rb1 <= VW'(c0) * VW'(nc) + VW'(r0) * VW'(ns);
        lo_off0 <= (ns[15] ? 17'(ns) : 17'sd0) + (cmd.c[15] ? 17'(cmd.c) : 17'sd0);
        hi_off0 <= (ns[15] ? 17'sd0 : 17'(ns)) + (cmd.c[15] ? 17'sd0 : 17'(cmd.c));
        lo_off1 <= (nc[15] ? 17'(nc) : 17'sd0) + (ns[15] ? 17'(ns) : 17'sd0);
        hi_off1 <= (nc[15] ? 17'sd0 : 17'(nc)) + (ns[15] ? 17'sd0 : 17'(ns));
        r_idx <= r0[RIW-1:0];
      end
      B_ROWRD: begin
        q_idx <= c0[CIW-1:0];
        v0    <= rb0;
        v1    <= rb1;
      end
      B_COLS: begin
        priority if (hit) begin
          res <= 1'b1;
        end else if (last_col) begin
          // advance to the next row
          r_idx <= r_idx + 1'b1;
          rb0   <= rb0 + VW'(cmd.c);
          rb1   <= rb1 + VW'(ns);
        end else begin
          q_idx <= q_idx + 1'b1;
          v0    <= v0 + VW'(ns);
          v1    <= v1 + VW'(nc);
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/rotated_rect_tile_wall_collision.sv]
// Top level of the rotated-rectangle tile-wall collision block.
// Depends on rrtw_pkg, rrtw_front, rrtw_cmdq and rrtw_back.
//
//   channel   handshake        payload
//   request   push / full      opcode, cell_row, cell_col, wall_bit, pos_x, pos_y,
//                              rect_width, rect_height, angle_deg, anchor_x, anchor_y
//   result    empty / pop      collides
//
// In the back part a write is taken, its row is read, modified and written back, and the result is posted.
// A query is taken, runs its geometry steps on the one shared multiplier, sets up its bounds,
// then walks the R by C cell box row by row, one cell per cycle after each row read,
// and posts the result; the walk stops at the first overlapping wall cell. A result that
// is not taken holds the back part in its result state.
// Reset clears per-row valid bits at once; no clearing pass is needed.
// Up to one request in the front register and two in the queue wait while the
// back part works or while a finished result is not taken.
module rotated_rect_tile_wall_collision import rrtw_pkg::*; #(
  parameter int MAP_ROWS = 32,
  parameter int MAP_COLS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               opcode,
  input  logic [4:0]         cell_row,
  input  logic [4:0]         cell_col,
  input  logic               wall_bit,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        rect_width,
  input  logic [15:0]        rect_height,
  input  logic [8:0]         angle_deg,
  input  logic [8:0]         anchor_x,
  input  logic [8:0]         anchor_y,
  output logic               empty,
  input  logic               pop,
  output logic               collides
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;

  rrtw_front #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .wall_bit    (wall_bit),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .angle_deg   (angle_deg),
    .anchor_x    (anchor_x),
    .anchor_y    (anchor_y),
    .q_push      (q_push),
    .q_item      (q_in),
    .q_full      (q_full)
  );

  rrtw_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_out),
    .empty    (q_empty)
  );

  rrtw_back #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .collides (collides)
  );

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back part took a request from an empty queue");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst) q_pop |=> !q_pop)
    else $error("back part took two requests in a row");
  a_full_means_queue_full: assert property (@(posedge clk) disable iff (rst) full |-> q_full)
    else $error("front stalled while the queue had room");
`endif

endmodule

[tb/testbench.sv]
// Testbench for rotated_rect_tile_wall_collision: drives random and directed cell writes
// and rectangle queries, and checks each collides result against a local predictor.
// Depends on rrtw_pkg (sine table) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import rrtw_pkg::*;

  localparam int ROWS = 32;
  localparam int COLS = 32;
  localparam int CYCLE_LIMIT = 6000000;

  typedef enum logic {OP_WRITE = 1'b0, OP_QUERY = 1'b1} op_t;

  typedef struct {
    op_t                op;
    logic [4:0]         row;
    logic [4:0]         col;
    logic               wall;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [8:0]         ang;
    logic [8:0]         anx;
    logic [8:0]         any;
  } request_t;

  class collision_board;
    bit     wall_map [ROWS*COLS];
    bit     pending [$];
    int     errors;

    function new();
      errors = 0;
      foreach (wall_map[i]) wall_map[i] = 1'b0;
    endfunction

    function longint sine(int d);
      d = d % 360;
      if (d <= 90) return SIN_TAB[d];
      if (d <= 180) return SIN_TAB[180-d];
      if (d <= 270) return -longint'(SIN_TAB[d-180]);
      return -longint'(SIN_TAB[360-d]);
    endfunction

    function bit separated(longint ax [4], longint ay [4], longint bx [4], longint by [4],
                           longint vx, longint vy);
      longint lo_a, hi_a, lo_b, hi_b, d;
      lo_a = ax[0]*vx + ay[0]*vy; hi_a = lo_a;
      lo_b = bx[0]*vx + by[0]*vy; hi_b = lo_b;
      for (int k = 1; k < 4; k++) begin
        d = ax[k]*vx + ay[k]*vy;
        if (d < lo_a) lo_a = d;
        if (d > hi_a) hi_a = d;
        d = bx[k]*vx + by[k]*vy;
        if (d < lo_b) lo_b = d;
        if (d > hi_b) hi_b = d;
      end
      return (hi_a < lo_b) || (hi_b < lo_a);
    endfunction

    function bit rect_hits_wall(request_t r);
      longint s, c, w, h, anx, any, cx, cy, one;
      longint lx [4], ly [4], px [4], py [4], qx [4], qy [4];
      longint minx, maxx, miny, maxy, r0, r1, c0, c1;
      bit hit;
      one = 64'sd1 <<< 30;
      w = longint'(r.w); h = longint'(r.h);
      anx = longint'(r.anx); any = longint'(r.any);
      s = sine(int'(r.ang));
      c = sine(int'(r.ang) + 90);
      cx = (2*longint'(r.px) + w) * (64'sd1 <<< 21);
      cy = (2*longint'(r.py) + h) * (64'sd1 <<< 21);
      lx[0] = -anx*w;       ly[0] = -any*h;
      lx[1] = (256-anx)*w;  ly[1] = -any*h;
      lx[2] = (256-anx)*w;  ly[2] = (256-any)*h;
      lx[3] = -anx*w;       ly[3] = (256-any)*h;
      for (int k = 0; k < 4; k++) begin
        px[k] = cx + lx[k]*c - ly[k]*s;
        py[k] = cy + lx[k]*s + ly[k]*c;
      end
      minx = px[0]; maxx = px[0]; miny = py[0]; maxy = py[0];
      for (int k = 1; k < 4; k++) begin
        if (px[k] < minx) minx = px[k];
        if (px[k] > maxx) maxx = px[k];
        if (py[k] < miny) miny = py[k];
        if (py[k] > maxy) maxy = py[k];
      end
      // arithmetic shift floors negative values too
      c0 = minx >>> 30; c1 = maxx >>> 30;
      r0 = miny >>> 30; r1 = maxy >>> 30;
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 > COLS-1) c1 = COLS-1;
      if (r1 > ROWS-1) r1 = ROWS-1;
      for (longint rr = r0; rr <= r1; rr++) begin
        for (longint qq = c0; qq <= c1; qq++) begin
          if (!wall_map[rr*COLS + qq]) continue;
          qx[0] = qq*one;     qy[0] = rr*one;
          qx[1] = (qq+1)*one; qy[1] = rr*one;
          qx[2] = (qq+1)*one; qy[2] = (rr+1)*one;
          qx[3] = qq*one;     qy[3] = (rr+1)*one;
          hit = 1'b1;
          if (w != 0 && separated(px, py, qx, qy, -s, c)) hit = 1'b0;
          if (h != 0 && separated(px, py, qx, qy, -c, -s)) hit = 1'b0;
          if (separated(px, py, qx, qy, 0, 1)) hit = 1'b0;
          if (separated(px, py, qx, qy, -1, 0)) hit = 1'b0;
          if (hit) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(request_t r);
      if (r.op == OP_WRITE) begin
        if (r.row < ROWS && r.col < COLS) wall_map[r.row*COLS + r.col] = r.wall;
        pending.push_back(1'b0);
      end else begin
        pending.push_back(rect_hits_wall(r));
      end
    endfunction

    function void check_result(bit got);
      bit want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: collides=%0d", got);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("collides mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full, empty, collides;
  logic               opcode = 1'b0;
  logic [4:0]         cell_row = '0;
  logic [4:0]         cell_col = '0;
  logic               wall_bit = 1'b0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [15:0]        rect_width = '0;
  logic [15:0]        rect_height = '0;
  logic [8:0]         angle_deg = '0;
  logic [8:0]         anchor_x = '0;
  logic [8:0]         anchor_y = '0;

  collision_board board = new();
  int             cycles = 0;

  rotated_rect_tile_wall_collision dut (
    .clk, .rst, .push, .full, .opcode, .cell_row, .cell_col, .wall_bit,
    .pos_x, .pos_y, .rect_width, .rect_height, .angle_deg, .anchor_x, .anchor_y,
    .empty, .pop, .collides
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random pop with occasional long stalls
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = gap_len();
      pop = (hold == 0);
      @(posedge clk);
      if (pop && !empty) board.check_result(collides);
      @(negedge clk);
      if (hold > 0) begin
        repeat (hold - 1) @(negedge clk);
        pop = 1'b1;
        @(posedge clk);
        if (!empty) board.check_result(collides);
        @(negedge clk);
      end
    end
  end

  task automatic send_request(request_t r);
    repeat (gap_len()) begin
      push = 1'b0;
      @(negedge clk);
    end
    opcode = r.op; cell_row = r.row; cell_col = r.col; wall_bit = r.wall;
    pos_x = r.px; pos_y = r.py; rect_width = r.w; rect_height = r.h;
    angle_deg = r.ang; anchor_x = r.anx; anchor_y = r.any;
    push = 1'b1;
    forever begin
      @(posedge clk);
      if (!full) break;
    end
    board.note_request(r);
    @(negedge clk);
    push = 1'b0;
  endtask

  function automatic request_t noise();
    request_t r;
    r.op = op_t'($urandom_range(1)); r.row = 5'($urandom); r.col = 5'($urandom);
    r.wall = 1'($urandom); r.px = 16'($urandom); r.py = 16'($urandom);
    r.w = 16'($urandom); r.h = 16'($urandom);
    r.ang = 9'($urandom); r.anx = 9'($urandom); r.any = 9'($urandom);
    return r;
  endfunction

  function automatic request_t make_write(int row, int col, bit wall);
    request_t r;
    r = noise();
    r.op = OP_WRITE; r.row = 5'(row); r.col = 5'(col); r.wall = wall;
    return r;
  endfunction

  function automatic request_t make_query(int x, int y, int w, int h, int ang, int ax, int ay);
    request_t r;
    r = noise();
    r.op = OP_QUERY; r.px = 16'(x); r.py = 16'(y); r.w = 16'(w); r.h = 16'(h);
    r.ang = 9'(ang); r.anx = 9'(ax); r.any = 9'(ay);
    return r;
  endfunction

  // mostly small rectangles near the grid, so the cell walk stays short
  function automatic request_t random_query();
    request_t r;
    int p;
    p = $urandom_range(99);
    r = make_query($urandom_range(36*256) - 2*256, $urandom_range(36*256) - 2*256,
                   $urandom_range(4*256), $urandom_range(4*256), $urandom_range(511),
                   ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256),
                   ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256));
    if (p < 3) r = noise();
    else if (p < 8) begin
      r.px = 16'($urandom); r.py = 16'($urandom);
    end
    r.op = OP_QUERY;
    return r;
  endfunction

  initial begin
    request_t r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(make_write(0, 0, 1'b1));
    send_request(make_write(31, 31, 1'b1));
    send_request(make_write(10, 20, 1'b1));
    send_request(make_write(10, 21, 1'b1));
    send_request(make_write(10, 21, 1'b0));
    send_request(make_query(0, 0, 256, 256, 0, 0, 0));
    send_request(make_query(31*256, 31*256, 256, 256, 45, 128, 128));
    send_request(make_query(20*256, 10*256, 128, 512, 90, 256, 256));
    send_request(make_query(21*256, 10*256, 200, 200, 180, 128, 128));
    send_request(make_query(20*256, 10*256, 256, 256, 270, 511, 511));
    send_request(make_query(20*256, 10*256, 256, 256, 359, 0, 256));
    send_request(make_query(20*256, 10*256, 256, 256, 360, 128, 128));
    send_request(make_query(20*256, 10*256, 256, 256, 511, 300, 300));
    send_request(make_query(20*256 + 64, 9*256, 0, 512, 30, 128, 128));
    send_request(make_query(19*256, 10*256 + 64, 512, 0, 60, 128, 128));
    send_request(make_query(20*256, 10*256, 0, 0, 0, 0, 0));
    send_request(make_query(-32768, -32768, 256, 256, 10, 0, 0));
    send_request(make_query(32767, 32767, 65535, 65535, 0, 0, 0));
    send_request(make_query(-32768, -32768, 65535, 65535, 123, 256, 256));
    send_request(make_query(-256, -256, 300, 300, 0, 0, 0));
    send_request(make_query(22*256, 12*256, 256, 256, 0, 0, 0));

    for (int i = 0; i < 1000; i++) begin
      if (i == 500) begin
        // drain everything before continuing
        while (board.pending.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 40)
        r = make_write($urandom_range(31), $urandom_range(31), $urandom_range(9) < 4);
      else
        r = random_query();
      send_request(r);
    end

    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
